FILE: sv/mrd_pkg.sv
// shared types and constants for the minimum repeat distance block
package mrd_pkg;

    // fixed field widths of the ports
    localparam int VALUE_W  = 10;
    localparam int DIST_W   = 16;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // sequence epoch stored with every table entry; zero marks a cleared entry
    localparam int EPOCH_BITS = 8;
    localparam logic [EPOCH_BITS-1:0] EPOCH_CLEAR = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = {EPOCH_BITS{1'b1}};

    // result queue geometry
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = 2;
    localparam int Q_CNT_BITS = 3;

    // one result item
    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] min_distance;
    } result_t;

endpackage

FILE: sv/mrd_pos_mem.sv
// position table: one write port and one read port with registered read data
module mrd_pos_mem #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 24
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/mrd_result_q.sv
// four-entry result queue between the table pipeline and the output channel
module mrd_result_q (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  mrd_pkg::result_t                push_data,
    input  logic                            pop_stall,
    output mrd_pkg::result_t                head,
    output logic                            head_valid,
    output logic [mrd_pkg::Q_CNT_BITS-1:0]  count
);

    mrd_pkg::result_t                     ent_reg [mrd_pkg::Q_DEPTH];
    logic [mrd_pkg::Q_PTR_BITS-1:0]       wr_ptr_reg;
    logic [mrd_pkg::Q_PTR_BITS-1:0]       rd_ptr_reg;
    logic [mrd_pkg::Q_CNT_BITS-1:0]       count_reg;
    logic [mrd_pkg::Q_PTR_BITS-1:0]       wr_ptr_next;
    logic [mrd_pkg::Q_PTR_BITS-1:0]       rd_ptr_next;
    logic [mrd_pkg::Q_CNT_BITS-1:0]       count_next;
    logic                                 pop;

    assign head_valid = (count_reg != '0);
    assign head       = ent_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign pop        = head_valid & ~pop_stall;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/min_repeat_distance.sv
// Minimum repeat distance: a closing element's result goes from stage 1 into the queue.
// One element per cycle: table read in the accept cycle, compare and write-back in the
// next, with same-entry forwarding; input also stalls when the result queue lacks room.
// Reset is asynchronous; after it, and after every 255 sequences when the epoch mark
// wraps, a clearing pass writes all 2^VALUE_BITS entries, one per cycle, with input
// stalled (also with the wrapping element in stage 1); result transfers go on meanwhile.
module min_repeat_distance #(
    parameter int VALUE_BITS = 10,
    parameter int INDEX_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mrd_pkg::VALUE_W-1:0] value,
    input  logic                        last,
    input  logic                        in_valid,
    output logic                        in_stall,
    output logic                        found,
    output logic [mrd_pkg::DIST_W-1:0]  min_distance,
    output logic                        out_valid,
    input  logic                        out_stall
);

    localparam int EB        = mrd_pkg::EPOCH_BITS;
    localparam int WORD_BITS = EB + INDEX_BITS;
    localparam int WIDE      = (INDEX_BITS > mrd_pkg::DIST_W) ? INDEX_BITS : mrd_pkg::DIST_W;

    typedef struct packed {
        logic [EB-1:0]         epoch;
        logic [INDEX_BITS-1:0] pos;
    } entry_t;

    logic                             in_fire;
    logic                             s1_valid_reg;
    logic [VALUE_BITS-1:0]            s1_addr_reg;
    logic                             s1_last_reg;
    logic                             fwd_valid_reg;
    logic [VALUE_BITS-1:0]            fwd_addr_reg;
    entry_t                           fwd_data_reg;
    logic [EB-1:0]                    epoch_reg;
    logic [EB-1:0]                    epoch_next;
    logic [INDEX_BITS-1:0]            pos_reg;
    logic [INDEX_BITS-1:0]            pos_next;
    logic [INDEX_BITS-1:0]            best_reg;
    logic [INDEX_BITS-1:0]            best_next;
    logic                             have_reg;
    logic                             have_next;
    logic                             sweep_reg;
    logic                             sweep_next;
    logic [VALUE_BITS-1:0]            sweep_cnt_reg;
    logic [VALUE_BITS-1:0]            sweep_cnt_next;
    logic [WORD_BITS-1:0]             rd_data;
    logic                             wr_en;
    logic [VALUE_BITS-1:0]            wr_addr;
    entry_t                           wr_entry;
    entry_t                           rd_entry;
    entry_t                           cur_entry;
    logic                             hit;
    logic [INDEX_BITS-1:0]            gap;
    logic                             take;
    logic [INDEX_BITS-1:0]            best_upd;
    logic                             have_upd;
    logic [INDEX_BITS-1:0]            pos_inc;
    logic [WIDE-1:0]                  best_wide;
    mrd_pkg::result_t                 res;
    logic                             push;
    logic                             wrap_pending;
    logic [mrd_pkg::Q_CNT_BITS-1:0]   q_count;
    logic [mrd_pkg::Q_CNT_BITS:0]     q_load;
    mrd_pkg::result_t                 head;

    // input side flow control
    assign wrap_pending = s1_valid_reg & s1_last_reg & (epoch_reg == mrd_pkg::EPOCH_MAX);
    assign q_load       = {1'b0, q_count} + {{mrd_pkg::Q_CNT_BITS{1'b0}}, push};
    assign in_stall     = sweep_reg | wrap_pending
                        | (q_load >= (mrd_pkg::Q_CNT_BITS + 1)'(mrd_pkg::Q_DEPTH));
    assign in_fire      = in_valid & ~in_stall;

    // position table
    mrd_pos_mem #(
        .ADDR_BITS (VALUE_BITS),
        .DATA_BITS (WORD_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (VALUE_BITS'(value)),
        .rd_data (rd_data)
    );

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_fire;
            fwd_valid_reg <= s1_valid_reg;
        end
    end

    // stage 1 payload and forwarding copy of the last write
    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= VALUE_BITS'(value);
        s1_last_reg  <= last;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= wr_entry;
    end

    // read-modify-write of the entry and running minimum
    always_comb
    begin
        rd_entry  = entry_t'(rd_data);
        cur_entry = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_entry;
        hit       = (cur_entry.epoch == epoch_reg);
        gap       = pos_reg - cur_entry.pos;
        take      = hit && (!have_reg || (gap < best_reg));
        best_upd  = take ? gap : best_reg;
        have_upd  = have_reg | hit;
        pos_inc   = (pos_reg == {INDEX_BITS{1'b1}}) ? pos_reg : pos_reg + 1'b1;
        best_wide = WIDE'(best_upd);

        res.found = have_upd;
        if (!have_upd)
        begin
            res.min_distance = '0;
        end
        else if (best_wide > WIDE'(mrd_pkg::DIST_MAX))
        begin
            res.min_distance = mrd_pkg::DIST_MAX;
        end
        else
        begin
            res.min_distance = mrd_pkg::DIST_W'(best_wide);
        end
    end

    // table write: clearing pass or stage 1 write-back
    always_comb
    begin
        wr_en = sweep_reg | s1_valid_reg;
        if (sweep_reg)
        begin
            wr_addr        = sweep_cnt_reg;
            wr_entry.epoch = mrd_pkg::EPOCH_CLEAR;
            wr_entry.pos   = '0;
        end
        else
        begin
            wr_addr        = s1_addr_reg;
            wr_entry.epoch = epoch_reg;
            wr_entry.pos   = pos_reg;
        end
    end

    assign push = s1_valid_reg & s1_last_reg;

    // sequence state, epoch and clearing pass
    always_comb
    begin
        epoch_next     = epoch_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (sweep_reg)
        begin
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
            if (sweep_cnt_reg == {VALUE_BITS{1'b1}})
            begin
                sweep_next = 1'b0;
            end
        end
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                pos_next  = '0;
                best_next = '0;
                have_next = 1'b0;
                if (epoch_reg == mrd_pkg::EPOCH_MAX)
                begin
                    epoch_next = mrd_pkg::EPOCH_FIRST;
                    sweep_next = 1'b1;
                end
                else
                begin
                    epoch_next = epoch_reg + 1'b1;
                end
            end
            else
            begin
                pos_next  = pos_inc;
                best_next = best_upd;
                have_next = have_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg     <= mrd_pkg::EPOCH_FIRST;
            pos_reg       <= '0;
            best_reg      <= '0;
            have_reg      <= 1'b0;
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            epoch_reg     <= epoch_next;
            pos_reg       <= pos_next;
            best_reg      <= best_next;
            have_reg      <= have_next;
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // result queue toward the output channel
    mrd_result_q u_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (res),
        .pop_stall  (out_stall),
        .head       (head),
        .head_valid (out_valid),
        .count      (q_count)
    );

    assign found        = head.found;
    assign min_distance = head.min_distance;

endmodule

FILE: sv/mrd_checker.sv
// port-level checker for the minimum repeat distance block, with its bind
module mrd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        last,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        found,
    input logic [mrd_pkg::DIST_W-1:0]  min_distance,
    input logic                        out_valid,
    input logic                        out_stall
);

    logic       in_xfer;
    logic       out_xfer;
    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    assign in_xfer  = in_valid & ~in_stall;
    assign out_xfer = out_valid & ~out_stall;

    // sequences closed but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        case ({in_xfer & last, out_xfer})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(min_distance))
        else $error("result changed while stalled");

    // no repeat means zero distance
    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> min_distance == '0)
        else $error("distance nonzero without a repeat");

    // every result belongs to a closed sequence
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> pending_reg != '0)
        else $error("result transfer without a closing element");

    // pipeline plus queue bound the backlog
    a_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(mrd_pkg::Q_DEPTH + 1))
        else $error("too many undelivered results");

endmodule

bind min_repeat_distance mrd_checker u_mrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .last         (last),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .found        (found),
    .min_distance (min_distance),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
);

FILE: sim/testbench.sv
// self-checking testbench for the minimum repeat distance block
`timescale 1ns / 1ps

module testbench;

    localparam int VALUE_BITS  = 10;
    localparam int INDEX_BITS  = 16;
    localparam int TABLE_DEPTH = 1 << VALUE_BITS;
    localparam logic [INDEX_BITS-1:0] POS_MAX = {INDEX_BITS{1'b1}};
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 12;

    logic                        clk;
    logic                        rst_n;
    logic [mrd_pkg::VALUE_W-1:0] value;
    logic                        last;
    logic                        in_valid;
    logic                        in_stall;
    logic                        found;
    logic [mrd_pkg::DIST_W-1:0]  min_distance;
    logic                        out_valid;
    logic                        out_stall;

    // idle and stall rates of the current phase, in percent
    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int idle_cycles;
    int elems_sent;

    // predictor state
    logic [INDEX_BITS-1:0] pos_table [TABLE_DEPTH];
    logic                  seen_mask [TABLE_DEPTH];
    logic [INDEX_BITS-1:0] elem_pos;
    logic [INDEX_BITS-1:0] best_gap;
    logic                  have_gap;

    mrd_pkg::result_t            expected_results[$];
    logic [mrd_pkg::VALUE_W-1:0] seq_buf[$];

    min_repeat_distance #(
        .VALUE_BITS(VALUE_BITS),
        .INDEX_BITS(INDEX_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .value(value),
        .last(last),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .found(found),
        .min_distance(min_distance),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // start a new sequence in the predictor
    task automatic clear_sequence_state();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            seen_mask[i] = 1'b0;
        end
        elem_pos = '0;
        best_gap = '0;
        have_gap = 1'b0;
    endtask

    // fold one element into the gap tracker; queue a result on the last one
    task automatic track_element(input logic [mrd_pkg::VALUE_W-1:0] v, input logic l);
        int                    idx;
        logic [INDEX_BITS-1:0] gap;
        mrd_pkg::result_t      r;
        idx = int'(v) % TABLE_DEPTH;
        if (seen_mask[idx])
        begin
            gap = elem_pos - pos_table[idx];
            if (!have_gap || gap < best_gap)
            begin
                best_gap = gap;
                have_gap = 1'b1;
            end
        end
        pos_table[idx] = elem_pos;
        seen_mask[idx] = 1'b1;
        if (elem_pos != POS_MAX)
        begin
            elem_pos = elem_pos + 1'b1;
        end
        if (l)
        begin
            r.found          = have_gap;
            r.min_distance   = have_gap ? mrd_pkg::DIST_W'(best_gap) : '0;
            expected_results = {expected_results, r};
            clear_sequence_state();
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // drive one element and wait for its transfer; called just after a falling edge
    task automatic send_elem(input logic [mrd_pkg::VALUE_W-1:0] v, input logic l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        track_element(v, l);
        elems_sent++;
        @(negedge clk);
    endtask

    // send the buffered elements as one sequence
    task automatic send_sequence();
        for (int i = 0; i < seq_buf.size(); i++)
        begin
            send_elem(seq_buf[i], i == seq_buf.size() - 1);
        end
        seq_buf.delete();
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        mrd_pkg::result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result found=%0b dist=%0d",
                                          found, min_distance));
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (found !== exp_r.found)
                begin
                    report_mismatch($sformatf("found %0b, expected %0b",
                                              found, exp_r.found));
                end
                if (min_distance !== exp_r.min_distance)
                begin
                    report_mismatch($sformatf("min_distance %0d, expected %0d",
                                              min_distance, exp_r.min_distance));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // extremes of the value range, short sequences, and clearing between sequences
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // single elements never repeat
        seq_buf = '{10'd0};
        send_sequence();
        seq_buf = '{10'd1023};
        send_sequence();
        // adjacent repeat
        seq_buf = '{10'd5, 10'd5};
        send_sequence();
        // alternating extremes
        seq_buf = '{10'd0, 10'd1023, 10'd0, 10'd1023};
        send_sequence();
        // later repeat gives the smaller gap
        seq_buf = '{10'd3, 10'd1, 10'd2, 10'd3, 10'd2};
        send_sequence();
        // several occurrences, gap taken to the most recent one
        seq_buf = '{10'd7, 10'd8, 10'd9, 10'd7, 10'd8, 10'd7};
        send_sequence();
        // no repeat
        seq_buf = '{10'd1, 10'd2, 10'd3};
        send_sequence();
        // same value across sequences must not count
        seq_buf = '{10'd9};
        send_sequence();
        seq_buf = '{10'd9};
        send_sequence();
    endtask

    // random sequences, mostly with content shaped to produce repeats
    task automatic test_random(input int idle_pct, input int stall_pct, input int n_elems);
        int len;
        int mode;
        int base;
        int span;
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = elems_sent + n_elems;
        while (elems_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(25, 80);
                1, 2, 3: len = $urandom_range(7, 24);
                default: len = $urandom_range(1, 6);
            endcase
            mode = $urandom_range(0, 2);
            base = $urandom_range(0, TABLE_DEPTH - 1);
            span = (mode == 1) ? $urandom_range(1, len / 2 + 2) : $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
            begin
                if (mode == 0)
                begin
                    seq_buf = {seq_buf,
                               mrd_pkg::VALUE_W'($urandom_range(0, TABLE_DEPTH - 1))};
                end
                else
                begin
                    seq_buf = {seq_buf,
                               mrd_pkg::VALUE_W'((base + $urandom_range(0, span))
                                                 % TABLE_DEPTH)};
                end
            end
            send_sequence();
        end
    endtask

    // stimulus and end of run
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        value          = '0;
        last           = 1'b0;
        out_stall      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        elems_sent     = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            pos_table[i] = '0;
        end
        clear_sequence_state();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(0, 0, 460);
        test_random(73, 0, 460);
        test_random(0, 73, 460);
        test_random(30, 30, 470);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
